[rtl/core/mk_pkg.sv]
`default_nettype none

package mk_pkg;

  // Field widths of the channels and the configuration port
  localparam int FIELD_W    = 32;
  localparam int EXT_W      = 31;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_EXTENT_Z = 3'd5;

  // Side information that travels with one axis through the divider stages
  typedef struct packed {
    logic under;    // below the box: grid 0
    logic over;     // at or above the top edge: grid max
    logic outside;  // strictly outside the box
  } mk_side_t;

endpackage

`default_nettype wire

[rtl/core/mk_pos_if.sv]
`default_nettype none

interface mk_pos_if
  import mk_pkg::*;
();
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] pos_x;
  logic [FIELD_W-1:0] pos_y;
  logic [FIELD_W-1:0] pos_z;
  logic               last_in;

  modport source (output valid, output pos_x, output pos_y, output pos_z,
                  output last_in, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input pos_z,
                  input last_in, output ready);
endinterface

`default_nettype wire

[rtl/core/mk_key_if.sv]
`default_nettype none

interface mk_key_if #(
  parameter int KEY_WIDTH = 64
) ();
  logic                 valid;
  logic                 ready;
  logic [KEY_WIDTH-1:0] tree_key;
  logic                 clamped;
  logic                 last_out;

  modport source (output valid, output tree_key, output clamped, output last_out,
                  input ready);
  modport sink   (input valid, input tree_key, input clamped, input last_out,
                  output ready);
endinterface

`default_nettype wire

[rtl/core/mk_axis_quant.sv]
`default_nettype none

// One axis: offset from the corner, range check, then a restoring divider
// that produces one grid bit per stage.
module mk_axis_quant
  import mk_pkg::*;
#(
  parameter int BITS_PER_AXIS = 21,
  parameter int POS_WIDTH     = 32
) (
  input  wire logic                     clk,
  input  wire logic                     adv,
  input  wire logic [FIELD_W-1:0]       pos,
  input  wire logic [FIELD_W-1:0]       corner,
  input  wire logic [EXT_W-1:0]         ext,
  output logic      [BITS_PER_AXIS-1:0] grid,
  output logic                          outside
);

  localparam int PW = POS_WIDTH;
  localparam int XW = (PW > FIELD_W) ? PW : FIELD_W;
  localparam int CW = (PW > EXT_W) ? PW : EXT_W;
  localparam int B  = BITS_PER_AXIS;

  logic [XW-1:0] pos_ext, cor_ext;
  logic [PW-1:0] pos_p, cor_p;
  logic [PW:0]   diff_nxt, diff_r;

  assign pos_ext  = XW'(pos);
  assign cor_ext  = XW'(corner);
  assign pos_p    = pos_ext[PW-1:0];
  assign cor_p    = cor_ext[PW-1:0];
  assign diff_nxt = {pos_p[PW-1], pos_p} - {cor_p[PW-1], cor_p};

  always_ff @(posedge clk) begin
    if (adv) begin
      diff_r <= diff_nxt;
    end
  end

  // Classify against the box
  logic [CW-1:0]    d_w, e_w;
  logic             neg, ge, gt;
  mk_side_t         side_nxt;
  logic [EXT_W-1:0] rem0_nxt;

  assign d_w = CW'(diff_r[PW-1:0]);
  assign e_w = CW'(ext);
  assign neg = diff_r[PW];
  assign ge  = (d_w >= e_w);
  assign gt  = (d_w > e_w);

  always_comb begin
    side_nxt.under   = neg;
    side_nxt.over    = !neg && ge;
    side_nxt.outside = neg || gt;
    // in range means d < ext < 2^31
    rem0_nxt = (neg || ge) ? '0 : d_w[EXT_W-1:0];
  end

  logic     [EXT_W-1:0] rem_c  [0:B-1];
  logic     [B-1:0]     q_c    [0:B];
  mk_side_t             side_c [0:B];

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_c[0]  <= rem0_nxt;
      side_c[0] <= side_nxt;
    end
  end

  assign q_c[0] = '0;

  for (genvar k = 0; k < B; k++) begin : g_step
    logic [EXT_W+1:0] sub;
    logic             take;

    assign sub  = {1'b0, rem_c[k], 1'b0} - {2'b00, ext};
    assign take = !sub[EXT_W+1];

    always_ff @(posedge clk) begin
      if (adv) begin
        q_c[k+1]    <= B'({q_c[k], take});
        side_c[k+1] <= side_c[k];
      end
    end

    if (k < B - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (adv) begin
          rem_c[k+1] <= take ? sub[EXT_W-1:0] : {rem_c[k][EXT_W-2:0], 1'b0};
        end
      end
    end
  end

  always_comb begin
    if (side_c[B].under) begin
      grid = '0;
    end else if (side_c[B].over) begin
      grid = '1;
    end else begin
      grid = q_c[B];
    end
  end

  assign outside = side_c[B].outside;

endmodule

`default_nettype wire

[rtl/core/morton_key_from_position_core.sv]
// 3-D Morton key generator, one particle position per transaction.
//
// in_ch  : positions pos_x/pos_y/pos_z (signed fixed point) plus last_in.
// out_ch : tree_key (marker bit on top, grid bits interleaved z,y,x with z
//          least significant), clamped, last_out.
// cfg_*  : write-only registers, corner x/y/z at index 0..2 and extent
//          x/y/z at 3..5; write them only while no transaction is in flight.
//          An extent of 0 is stored as 1.
//
// Each axis runs through its own divider pipeline, one quotient bit per
// stage, and the interleaved key is registered in the output stage that
// drives out_ch. One transaction enters per cycle unless out_ch stalls.
// The whole pipeline advances on one enable: when out_ch holds a result
// that is not taken, every stage holds and in_ch.ready drops in the same
// cycle. Reset clears all valid bits and sets corners to 0, extents to 1.
`default_nettype none

module morton_key_from_position_core
  import mk_pkg::*;
#(
  parameter int BITS_PER_AXIS = 21,
  parameter int KEY_WIDTH     = 64,
  parameter int POS_WIDTH     = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  mk_pos_if.sink                     in_ch,
  mk_key_if.source                   out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int LAT = BITS_PER_AXIS + 2;

  // Configuration registers
  logic [FIELD_W-1:0] corner_x_r, corner_y_r, corner_z_r;
  logic [EXT_W-1:0]   extent_x_r, extent_y_r, extent_z_r;
  logic [EXT_W-1:0]   ext_wr;

  assign ext_wr = (cfg_data[EXT_W-1:0] == '0) ? EXT_W'(1) : cfg_data[EXT_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      corner_x_r <= '0;
      corner_y_r <= '0;
      corner_z_r <= '0;
      extent_x_r <= EXT_W'(1);
      extent_y_r <= EXT_W'(1);
      extent_z_r <= EXT_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CORNER_X: corner_x_r <= cfg_data[FIELD_W-1:0];
        CFG_CORNER_Y: corner_y_r <= cfg_data[FIELD_W-1:0];
        CFG_CORNER_Z: corner_z_r <= cfg_data[FIELD_W-1:0];
        CFG_EXTENT_X: extent_x_r <= ext_wr;
        CFG_EXTENT_Y: extent_y_r <= ext_wr;
        CFG_EXTENT_Z: extent_z_r <= ext_wr;
        default: ;
      endcase
    end
  end

  // Global pipeline enable
  logic adv;
  logic out_valid_r;

  assign adv         = !out_valid_r || out_ch.ready;
  // no transaction is taken while reset is held
  assign in_ch.ready = adv && rst_n;

  logic [LAT-1:0] vld_r;
  logic [LAT-1:0] last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= LAT'({vld_r, in_ch.valid});
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      last_r <= LAT'({last_r, in_ch.last_in});
    end
  end

  logic [BITS_PER_AXIS-1:0] gx, gy, gz;
  logic                     ox, oy, oz;

  mk_axis_quant #(.BITS_PER_AXIS(BITS_PER_AXIS), .POS_WIDTH(POS_WIDTH)) u_qx (
    .clk(clk), .adv(adv), .pos(in_ch.pos_x), .corner(corner_x_r), .ext(extent_x_r),
    .grid(gx), .outside(ox)
  );

  mk_axis_quant #(.BITS_PER_AXIS(BITS_PER_AXIS), .POS_WIDTH(POS_WIDTH)) u_qy (
    .clk(clk), .adv(adv), .pos(in_ch.pos_y), .corner(corner_y_r), .ext(extent_y_r),
    .grid(gy), .outside(oy)
  );

  mk_axis_quant #(.BITS_PER_AXIS(BITS_PER_AXIS), .POS_WIDTH(POS_WIDTH)) u_qz (
    .clk(clk), .adv(adv), .pos(in_ch.pos_z), .corner(corner_z_r), .ext(extent_z_r),
    .grid(gz), .outside(oz)
  );

  // Bit interleave; anything that would reach the marker bit is dropped
  logic [KEY_WIDTH-1:0] key_nxt;

  assign key_nxt[KEY_WIDTH-1] = 1'b1;

  for (genvar i = 0; i < KEY_WIDTH - 1; i++) begin : g_key
    localparam int J = i / 3;
    localparam int L = i % 3;
    if (J < BITS_PER_AXIS) begin : g_bit
      if (L == 0) begin : g_z
        assign key_nxt[i] = gz[J];
      end else if (L == 1) begin : g_y
        assign key_nxt[i] = gy[J];
      end else begin : g_x
        assign key_nxt[i] = gx[J];
      end
    end else begin : g_zero
      assign key_nxt[i] = 1'b0;
    end
  end

  // Output register
  logic [KEY_WIDTH-1:0] key_r;
  logic                 clamped_r;
  logic                 last_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vld_r[LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      key_r      <= key_nxt;
      clamped_r  <= ox || oy || oz;
      last_out_r <= last_r[LAT-1];
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.tree_key = key_r;
  assign out_ch.clamped  = clamped_r;
  assign out_ch.last_out = last_out_r;

endmodule

`default_nettype wire

[rtl/core/mk_checker.sv]
`default_nettype none

module mk_checker #(
  parameter int KEY_WIDTH = 64
) (
  input wire logic                 clk,
  input wire logic                 rst_n,
  input wire logic                 in_ready,
  input wire logic                 out_valid,
  input wire logic                 out_ready,
  input wire logic [KEY_WIDTH-1:0] out_key,
  input wire logic                 out_clamped,
  input wire logic                 out_last
);

  // Reset empties the output stage
  a_reset_empty: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

  // An empty output stage never back-pressures the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // Every key carries the marker bit on top
  a_marker: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_key[KEY_WIDTH-1])
    else $error("tree key without marker bit");

  // A stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key)
      && $stable(out_clamped) && $stable(out_last))
    else $error("stalled result changed");

endmodule

bind morton_key_from_position_core mk_checker #(.KEY_WIDTH(KEY_WIDTH)) u_mk_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_key     (out_ch.tree_key),
  .out_clamped (out_ch.clamped),
  .out_last    (out_ch.last_out)
);

`default_nettype wire
